// ===== design/rabs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the running-average background subtraction unit.
// No dependencies; imported by rabs_update and the top level.
package rabs_pkg;

  // One BGR pixel, packed as it sits in the background store: red 23:16, green 15:8, blue 7:0.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Item kinds.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_Y = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic signed [8:0] THRESHOLD_RST = 9'sd20;
  localparam logic [15:0]       ALPHA_RST     = 16'd2185;
  localparam logic [9:0]        CORNER_A_X_RST = 10'd0;
  localparam logic [8:0]        CORNER_A_Y_RST = 9'd0;
  localparam logic [9:0]        CORNER_B_X_RST = 10'd640;
  localparam logic [8:0]        CORNER_B_Y_RST = 9'd480;

  // Q8 luminance weights; they sum to 256.
  localparam logic signed [17:0] WEIGHT_R = 18'sd77;
  localparam logic signed [17:0] WEIGHT_G = 18'sd150;
  localparam logic signed [17:0] WEIGHT_B = 18'sd29;

endpackage

// ===== design/rabs_update.sv =====
`timescale 1ns / 1ps
// Per-pixel decision and background blend for one segment transaction.
// Depends on rabs_pkg for the pixel type and the luminance weights.
module rabs_update import rabs_pkg::*; (
  input  pix_t              pixel_i,
  input  pix_t              backgr_i,
  input  logic signed [8:0] threshold_i,
  input  logic [15:0]       alpha_i,
  output logic              foreground_o,
  output pix_t              blended_o
);

  // floor((alpha*p + (65536-alpha)*b) / 65536), rewritten as b + alpha*(p-b)/65536.
  function automatic logic [7:0] blend_channel(input logic [7:0] p, input logic [7:0] b,
                                               input logic [15:0] alpha);
    logic signed [8:0]  diff;
    logic signed [25:0] prod;
    logic signed [25:0] acc;
    diff = $signed({1'b0, p}) - $signed({1'b0, b});
    prod = $signed({10'b0, alpha}) * 26'(diff);
    acc  = $signed({2'b0, b, 16'b0}) + prod;
    return acc[23:16];
  endfunction

  logic signed [8:0]  diff_r, diff_g, diff_b;
  logic signed [17:0] luma_diff;
  logic signed [17:0] thr_scaled;

  always_comb begin
    diff_r     = $signed({1'b0, pixel_i.red})   - $signed({1'b0, backgr_i.red});
    diff_g     = $signed({1'b0, pixel_i.green}) - $signed({1'b0, backgr_i.green});
    diff_b     = $signed({1'b0, pixel_i.blue})  - $signed({1'b0, backgr_i.blue});
    luma_diff  = WEIGHT_R * 18'(diff_r) + WEIGHT_G * 18'(diff_g) + WEIGHT_B * 18'(diff_b);
    thr_scaled = $signed({threshold_i[8], threshold_i, 8'b0});
    // Signed comparison: a large negative difference still counts as background.
    foreground_o = !(luma_diff < thr_scaled);
    blended_o.red   = blend_channel(pixel_i.red,   backgr_i.red,   alpha_i);
    blended_o.green = blend_channel(pixel_i.green, backgr_i.green, alpha_i);
    blended_o.blue  = blend_channel(pixel_i.blue,  backgr_i.blue,  alpha_i);
  end

endmodule

// ===== design/running_average_background_subtract_unit.sv =====
`timescale 1ns / 1ps
// Running-average background subtraction: the store sits in one synchronous RAM of
// IMAGE_WIDTH*IMAGE_HEIGHT 24-bit entries, one read and one write port per clock.
// Depends on rabs_pkg and rabs_update.
//
// The unit takes one pixel transaction per clock while results are taken, and passes each
// through stage one and the output register. The rate is set by the background RAM: the
// entry is read when a transaction is accepted, checked and blended in stage one, and
// written back as it leaves stage one, so each pixel uses the read port once and the
// write port once. A pixel that hits the entry being written back in the same cycle
// takes the new value from a forwarding register. Results wait in an output register, so a
// new pixel is accepted while a result is still pending. The store has no reset: a segment
// pixel must follow a load of the same coordinates, and there is no clearing pass.
module running_average_background_subtract_unit import rabs_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [9:0]            pix_x_i,
  input  logic [8:0]            pix_y_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            red_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  foreground_o,
  output logic                  in_region_o
);

  localparam int unsigned DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COORD_W = 13;
  localparam logic [ADDR_W-1:0]  WIDTH_A  = ADDR_W'(IMAGE_WIDTH);
  localparam logic [COORD_W-1:0] WIDTH_C  = COORD_W'(IMAGE_WIDTH);
  localparam logic [COORD_W-1:0] HEIGHT_C = COORD_W'(IMAGE_HEIGHT);

  // Configuration registers.
  logic signed [8:0] threshold_q;
  logic [15:0]       alpha_q;
  logic [9:0]        corner_a_x_q, corner_b_x_q;
  logic [8:0]        corner_a_y_q, corner_b_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      alpha_q      <= ALPHA_RST;
      corner_a_x_q <= CORNER_A_X_RST;
      corner_a_y_q <= CORNER_A_Y_RST;
      corner_b_x_q <= CORNER_B_X_RST;
      corner_b_y_q <= CORNER_B_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_THRESHOLD:  threshold_q  <= $signed(cfg_data_i[8:0]);
        REG_ALPHA:      alpha_q      <= cfg_data_i;
        REG_CORNER_A_X: corner_a_x_q <= cfg_data_i[9:0];
        REG_CORNER_A_Y: corner_a_y_q <= cfg_data_i[8:0];
        REG_CORNER_B_X: corner_b_x_q <= cfg_data_i[9:0];
        REG_CORNER_B_Y: corner_b_y_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic accept;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Address and region of the incoming pixel.
  logic              on_image;
  logic              in_region;
  logic [ADDR_W-1:0] addr;
  logic [9:0]        lo_x, hi_x;
  logic [8:0]        lo_y, hi_y;

  always_comb begin
    on_image = (COORD_W'(pix_x_i) < WIDTH_C) && (COORD_W'(pix_y_i) < HEIGHT_C);
    addr     = ADDR_W'(pix_y_i) * WIDTH_A + ADDR_W'(pix_x_i);
    lo_x = (corner_a_x_q < corner_b_x_q) ? corner_a_x_q : corner_b_x_q;
    hi_x = (corner_a_x_q > corner_b_x_q) ? corner_a_x_q : corner_b_x_q;
    lo_y = (corner_a_y_q < corner_b_y_q) ? corner_a_y_q : corner_b_y_q;
    hi_y = (corner_a_y_q > corner_b_y_q) ? corner_a_y_q : corner_b_y_q;
    // Strictly inside: min+1 <= v < max-1, written as v > min and v+1 < max.
    in_region = on_image
             && (pix_x_i > lo_x) && ((11'(pix_x_i) + 11'd1) < 11'(hi_x))
             && (pix_y_i > lo_y) && ((10'(pix_y_i) + 10'd1) < 10'(hi_y));
  end

  // Stage one registers.
  logic              s1_kind_q;
  logic              s1_on_image_q;
  logic              s1_in_region_q;
  logic [ADDR_W-1:0] s1_addr_q;
  pix_t              s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q      <= kind_i;
      s1_on_image_q  <= on_image;
      s1_in_region_q <= in_region;
      s1_addr_q      <= addr;
      s1_pix_q       <= '{red: red_i, green: green_i, blue: blue_i};
    end
  end

  // Background store.
  logic [23:0]       bg_mem_q [DEPTH];
  logic [23:0]       rd_data_q;
  logic              mem_we;
  logic [23:0]       mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bg_mem_q[s1_addr_q] <= mem_wdata;
    end
    if (accept) begin
      rd_data_q <= bg_mem_q[addr];
    end
  end

  // Forwarding: a read in the same cycle as a write to that entry returns the old data.
  logic        fwd_hit_q;
  logic [23:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (accept) begin
      fwd_hit_q <= mem_we && (s1_addr_q == addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= mem_wdata;
    end
  end

  // Decision and blend.
  pix_t backgr;
  pix_t blended;
  logic upd_fg;
  logic seg_hit;

  assign backgr = fwd_hit_q ? pix_t'(fwd_data_q) : pix_t'(rd_data_q);

  rabs_update u_update (
    .pixel_i      (s1_pix_q),
    .backgr_i     (backgr),
    .threshold_i  (threshold_q),
    .alpha_i      (alpha_q),
    .foreground_o (upd_fg),
    .blended_o    (blended)
  );

  always_comb begin
    seg_hit = (s1_kind_q == KIND_SEGMENT) && s1_in_region_q;
    mem_we  = s1_adv && (((s1_kind_q == KIND_LOAD) && s1_on_image_q) || (seg_hit && !upd_fg));
    mem_wdata = (s1_kind_q == KIND_LOAD) ? 24'(s1_pix_q) : 24'(blended);
  end

  // Output register.
  logic fg_q;
  logic region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fg_q     <= seg_hit && upd_fg;
      region_q <= seg_hit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign foreground_o = fg_q;
  assign in_region_o  = region_q;

endmodule

// ===== dv/tb_running_average_background_subtract_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for running_average_background_subtract_unit: drives pixel
// transactions and register writes, predicts each verdict and compares it field by field.
// Depends on rabs_pkg and the unit itself.
module tb_running_average_background_subtract_unit;
  import rabs_pkg::*;

  localparam int IMG_W          = 640;
  localparam int IMG_H          = 480;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;

  // Keeps a private copy of the background and the registers, and the verdicts still owed.
  class background_tracker;
    typedef struct packed {
      logic fg;
      logic in_reg;
    } verdict_t;

    pix_t              bg_copy [int unsigned];
    logic signed [8:0] thr_q;
    logic [15:0]       alpha_q16;
    logic [9:0]        ax, bx;
    logic [8:0]        ay, by;
    verdict_t          pending_verdicts [$];
    int unsigned       mismatches;

    function new();
      thr_q      = THRESHOLD_RST;
      alpha_q16  = ALPHA_RST;
      ax         = CORNER_A_X_RST;
      ay         = CORNER_A_Y_RST;
      bx         = CORNER_B_X_RST;
      by         = CORNER_B_Y_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD:  thr_q = data[8:0];
        REG_ALPHA:      alpha_q16 = data;
        REG_CORNER_A_X: ax = data[9:0];
        REG_CORNER_A_Y: ay = data[8:0];
        REG_CORNER_B_X: bx = data[9:0];
        REG_CORNER_B_Y: by = data[8:0];
        default: ;
      endcase
    endfunction

    function bit on_image(logic [9:0] x, logic [8:0] y);
      return int'(x) < IMG_W && int'(y) < IMG_H;
    endfunction

    // The span excludes both corner rows and the one just below the upper corner.
    function bit in_span(int v, int a, int b);
      int lo, hi;
      lo = (a < b ? a : b) + 1;
      hi = (a > b ? a : b) - 1;
      return v >= lo && v < hi;
    endfunction

    function bit reads_store(logic [9:0] x, logic [8:0] y);
      return on_image(x, y) && in_span(x, ax, bx) && in_span(y, ay, by);
    endfunction

    function logic [7:0] blend(logic [7:0] p, logic [7:0] b);
      logic [31:0] acc;
      acc = 32'(alpha_q16) * 32'(p) + (32'd65536 - 32'(alpha_q16)) * 32'(b);
      return acc[23:16];
    endfunction

    function void note_pixel(logic kind, logic [9:0] x, logic [8:0] y, pix_t px);
      verdict_t    v;
      pix_t        bg;
      int unsigned addr;
      int          diff;
      v    = '0;
      addr = int'(y) * IMG_W + int'(x);
      if (kind == KIND_LOAD) begin
        if (on_image(x, y)) bg_copy[addr] = px;
      end else if (reads_store(x, y)) begin
        v.in_reg = 1'b1;
        bg       = bg_copy[addr];
        diff = int'(WEIGHT_R) * (int'(px.red) - int'(bg.red)) +
               int'(WEIGHT_G) * (int'(px.green) - int'(bg.green)) +
               int'(WEIGHT_B) * (int'(px.blue) - int'(bg.blue));
        if (diff < int'(thr_q) * 256) begin
          bg_copy[addr] = '{red:   blend(px.red, bg.red),
                            green: blend(px.green, bg.green),
                            blue:  blend(px.blue, bg.blue)};
        end else begin
          v.fg = 1'b1;
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic fg, logic in_reg);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got fg=%0b in_region=%0b",
                 $time, fg, in_reg);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (fg !== want.fg) begin
        $display("%0t: foreground mismatch, expected %0b, got %0b", $time, want.fg, fg);
        mismatches++;
      end
      if (in_reg !== want.in_reg) begin
        $display("%0t: in_region mismatch, expected %0b, got %0b", $time, want.in_reg, in_reg);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  kind_i      = KIND_LOAD;
  logic [9:0]            pix_x_i     = '0;
  logic [8:0]            pix_y_i     = '0;
  logic [7:0]            blue_i      = '0;
  logic [7:0]            green_i     = '0;
  logic [7:0]            red_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  foreground_o;
  logic                  in_region_o;

  background_tracker tracker = new();

  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int          cfg_ax = CORNER_A_X_RST, cfg_bx = CORNER_B_X_RST;
  int          cfg_ay = CORNER_A_Y_RST, cfg_by = CORNER_B_Y_RST;
  pix_t        load_hint [int unsigned];
  int unsigned loaded_addrs [$];
  int unsigned last_addr = 0;

  running_average_background_subtract_unit #(
    .IMAGE_WIDTH  (IMG_W),
    .IMAGE_HEIGHT (IMG_H)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .pix_x_i      (pix_x_i),
    .pix_y_i      (pix_y_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .foreground_o (foreground_o),
    .in_region_o  (in_region_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_verdict(foreground_o, in_region_o);
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req    = 1'b0;
        out_ready_i = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic pix_t grey(logic [7:0] v);
    return '{red: v, green: v, blue: v};
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 48)) - 24;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Offers one pixel transaction and returns once it has been accepted.
  task automatic send_pixel(input logic kind, input logic [9:0] x, input logic [8:0] y,
                            input pix_t px);
    int unsigned addr;
    addr = int'(y) * IMG_W + int'(x);
    if (kind == KIND_LOAD && tracker.on_image(x, y)) begin
      if (!load_hint.exists(addr)) loaded_addrs.push_back(addr);
      load_hint[addr] = px;
    end
    last_addr = addr;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i     = kind;
    pix_x_i    = x;
    pix_y_i    = y;
    blue_i     = px.blue;
    green_i    = px.green;
    red_i      = px.red;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_pixel(kind, x, y, px);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input int thr, input int alpha, input int ax, input int ay,
                           input int bx, input int by);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{REG_THRESHOLD, REG_ALPHA, REG_CORNER_A_X, REG_CORNER_A_Y,
            REG_CORNER_B_X, REG_CORNER_B_Y};
    val = '{16'(thr), 16'(alpha), 16'(ax), 16'(ay), 16'(bx), 16'(by)};
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_index_i = idx[i];
      cfg_data_i  = val[i];
      tracker.set_reg(idx[i], val[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_ax   = ax;
    cfg_ay   = ay;
    cfg_bx   = bx;
    cfg_by   = by;
  endtask

  // Mostly loads and segments on pixels already loaded, so the blend path is exercised
  // repeatedly; the rest is noise over the whole coordinate range.
  task automatic run_random(input int n_items);
    logic        kind;
    logic [9:0]  x;
    logic [8:0]  y;
    pix_t        px;
    int unsigned addr;
    int          pick, xl, xh, yl, yh;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      px   = pix_t'(24'($urandom));
      if (pick < 30 || loaded_addrs.size() == 0) begin
        kind = KIND_LOAD;
        xl = cfg_ax < cfg_bx ? cfg_ax : cfg_bx;
        xh = cfg_ax < cfg_bx ? cfg_bx : cfg_ax;
        yl = cfg_ay < cfg_by ? cfg_ay : cfg_by;
        yh = cfg_ay < cfg_by ? cfg_by : cfg_ay;
        if (xh > IMG_W - 1) xh = IMG_W - 1;
        if (yh > IMG_H - 1) yh = IMG_H - 1;
        if (xl > xh) xl = xh;
        if (yl > yh) yl = yh;
        if ($urandom_range(0, 4) != 0) begin
          x = 10'($urandom_range(xh, xl));
          y = 9'($urandom_range(yh, yl));
        end else begin
          x = 10'($urandom_range(IMG_W - 1, 0));
          y = 9'($urandom_range(IMG_H - 1, 0));
        end
      end else if (pick < 85) begin
        kind = KIND_SEGMENT;
        if ($urandom_range(0, 2) == 0 && load_hint.exists(last_addr)) addr = last_addr;
        else addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1, 0)];
        x = 10'(addr % IMG_W);
        y = 9'(addr / IMG_W);
        if ($urandom_range(0, 1) == 1) begin
          px = '{red:   nudge(load_hint[addr].red),
                 green: nudge(load_hint[addr].green),
                 blue:  nudge(load_hint[addr].blue)};
        end
      end else begin
        kind = 1'($urandom_range(1, 0));
        x    = 10'($urandom_range(1023, 0));
        y    = 9'($urandom_range(511, 0));
        // A segment would read an entry that was never loaded: turn it into a load.
        if (kind == KIND_SEGMENT && tracker.reads_store(x, y) &&
            !load_hint.exists(int'(y) * IMG_W + int'(x)))
          kind = KIND_LOAD;
      end
      send_pixel(kind, x, y, px);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings: image corners, pixels off the image,
    // region edges, both extremes of the difference, the exact threshold, and
    // back-to-back updates of one pixel.
    send_pixel(KIND_LOAD, 10'd0, 9'd0, grey(8'h00));
    send_pixel(KIND_LOAD, 10'd639, 9'd479, grey(8'hff));
    send_pixel(KIND_LOAD, 10'd1, 9'd1, grey(8'h00));
    send_pixel(KIND_LOAD, 10'd638, 9'd478, grey(8'hff));
    send_pixel(KIND_LOAD, 10'd2, 9'd2, grey(8'd100));
    send_pixel(KIND_LOAD, 10'd1023, 9'd511, grey(8'h5a));
    send_pixel(KIND_LOAD, 10'd640, 9'd0, grey(8'ha5));
    send_pixel(KIND_SEGMENT, 10'd1023, 9'd511, grey(8'hff));
    send_pixel(KIND_SEGMENT, 10'd0, 9'd0, grey(8'hff));
    send_pixel(KIND_SEGMENT, 10'd639, 9'd479, grey(8'h00));
    send_pixel(KIND_SEGMENT, 10'd1, 9'd1, grey(8'hff));
    send_pixel(KIND_SEGMENT, 10'd638, 9'd478, grey(8'h00));
    send_pixel(KIND_SEGMENT, 10'd638, 9'd478, grey(8'h00));
    send_pixel(KIND_SEGMENT, 10'd2, 9'd2, grey(8'd120));
    send_pixel(KIND_SEGMENT, 10'd2, 9'd2, grey(8'd119));
    send_pixel(KIND_SEGMENT, 10'd2, 9'd2, grey(8'd119));
    send_pixel(KIND_SEGMENT, 10'd1, 9'd1, grey(8'h00));
    send_pixel(KIND_SEGMENT, 10'd0, 9'd1, grey(8'h80));
    send_pixel(KIND_SEGMENT, 10'd639, 9'd1, grey(8'h80));
    send_pixel(KIND_SEGMENT, 10'd1, 9'd0, grey(8'h80));
    send_pixel(KIND_SEGMENT, 10'd1, 9'd479, grey(8'h80));
    run_random(70);

    configure(-255, 65535, 640, 480, 0, 0);
    run_random(80);
    configure(255, 0, 10, 5, 40, 30);
    run_random(80);
    configure(0, 32768, 100, 100, 100, 100);
    run_random(30);
    configure(int'($urandom_range(510, 0)) - 255, int'($urandom_range(65535, 0)),
              int'($urandom_range(640, 0)), int'($urandom_range(480, 0)),
              int'($urandom_range(640, 0)), int'($urandom_range(480, 0)));
    run_random(90);

    // The receiver holds off long enough for the unit to fill and refuse input.
    configure(20, 2185, 0, 0, 640, 480);
    hold_req = 1'b1;
    run_random(90);

    configure(-40, 1, 3, 2, 30, 20);
    idle_on = 1'b0;
    run_random(90);

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
